/* hw/rtl/pbc_pkg.sv */
// ----------------------------------------------------------------------------
// Playout buffer controller package
// Shared widths, codes, reset values and item types of the playout controller.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int TS_W    = 32;
  localparam int CFG_W   = 16;
  localparam int STEPS_W = 6;
  localparam int RMS_W   = 16;

  localparam logic [TS_W-1:0]    LAST_SPAN_RST  = TS_W'(100);
  localparam logic [RMS_W-1:0]   RECACHE_MS_RST = RMS_W'(500);
  localparam logic [STEPS_W-1:0] STEPS_RST      = STEPS_W'(1);
  localparam logic [6:0]         STEP_MS        = 7'd100;

  localparam logic [CFG_W-1:0]   REDUNDANCY_RST = CFG_W'(200);
  localparam logic [CFG_W-1:0]   FAST_PLAY_RST  = CFG_W'(1500);
  localparam logic [CFG_W-1:0]   START_SPAN_RST = CFG_W'(1000);
  localparam logic [STEPS_W-1:0] MAX_STEPS_RST  = STEPS_W'(30);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_VIDEO  = 2'd1,
    KIND_AUDIO  = 2'd2,
    KIND_PLAYED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_REDUNDANCY = 2'd0,
    CFG_FAST_PLAY  = 2'd1,
    CFG_START_SPAN = 2'd2,
    CFG_MAX_STEPS  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_FAST    = 3'b001,
    MODE_NORMAL  = 3'b010,
    MODE_RECACHE = 3'b100
  } mode_t;

  localparam logic [1:0] PLAY_ST_FAST    = 2'd0;
  localparam logic [1:0] PLAY_ST_NORMAL  = 2'd1;
  localparam logic [1:0] PLAY_ST_RECACHE = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0]   redundancy_ms;
    logic [CFG_W-1:0]   fast_play_ms;
    logic [CFG_W-1:0]   start_span_ms;
    logic [STEPS_W-1:0] max_cache_steps;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [TS_W-1:0] now_ms;
    logic [TS_W-1:0] packet_ts;
    logic            audio_present;
    logic [TS_W-1:0] audio_front_ts;
    logic [TS_W-1:0] audio_back_ts;
    logic            video_present;
    logic [TS_W-1:0] video_front_ts;
    logic [TS_W-1:0] video_back_ts;
  } in_item_t;

  typedef struct packed {
    logic            start_play;
    logic            pause_play;
    logic            release_video;
    logic [1:0]      play_state;
    logic            fast_audio;
    logic [TS_W-1:0] buffered_ms;
    logic [TS_W-1:0] play_position;
  } out_item_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] code;
    unique case (m)
      MODE_FAST:   code = PLAY_ST_FAST;
      MODE_NORMAL: code = PLAY_ST_NORMAL;
      default:     code = PLAY_ST_RECACHE;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/pbc_if.sv */
// ----------------------------------------------------------------------------
// Playout buffer controller channels
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface pbc_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [pbc_pkg::TS_W-1:0] now_ms;
  logic [pbc_pkg::TS_W-1:0] packet_ts;
  logic                     audio_present;
  logic [pbc_pkg::TS_W-1:0] audio_front_ts;
  logic [pbc_pkg::TS_W-1:0] audio_back_ts;
  logic                     video_present;
  logic [pbc_pkg::TS_W-1:0] video_front_ts;
  logic [pbc_pkg::TS_W-1:0] video_back_ts;

  modport source (output valid, kind, now_ms, packet_ts, audio_present, audio_front_ts,
                  audio_back_ts, video_present, video_front_ts, video_back_ts,
                  input ready);
  modport sink   (input valid, kind, now_ms, packet_ts, audio_present, audio_front_ts,
                  audio_back_ts, video_present, video_front_ts, video_back_ts,
                  output ready);
endinterface

interface pbc_out_if;
  logic                     valid;
  logic                     ready;
  logic                     start_play;
  logic                     pause_play;
  logic                     release_video;
  logic [1:0]               play_state;
  logic                     fast_audio;
  logic [pbc_pkg::TS_W-1:0] buffered_ms;
  logic [pbc_pkg::TS_W-1:0] play_position;

  modport source (output valid, start_play, pause_play, release_video, play_state,
                  fast_audio, buffered_ms, play_position, input ready);
  modport sink   (input valid, start_play, pause_play, release_video, play_state,
                  fast_audio, buffered_ms, play_position, output ready);
endinterface

/* hw/rtl/pbc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Playout buffer controller configuration registers
// Write-only register file for thresholds and the re-cache step limit.
// ----------------------------------------------------------------------------
module pbc_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [pbc_pkg::CFG_W-1:0] cfg_wdata,
  output pbc_pkg::cfg_t        cfg_o
);
  import pbc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.redundancy_ms   <= REDUNDANCY_RST;
      cfg_r.fast_play_ms    <= FAST_PLAY_RST;
      cfg_r.start_span_ms   <= START_SPAN_RST;
      cfg_r.max_cache_steps <= MAX_STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REDUNDANCY: cfg_r.redundancy_ms   <= cfg_wdata;
        CFG_FAST_PLAY:  cfg_r.fast_play_ms    <= cfg_wdata;
        CFG_START_SPAN: cfg_r.start_span_ms   <= cfg_wdata;
        CFG_MAX_STEPS:  cfg_r.max_cache_steps <= cfg_wdata[STEPS_W-1:0];
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* hw/rtl/pbc_ctrl.sv */
// ----------------------------------------------------------------------------
// Playout buffer controller state update
// Playout clock, fast start / normal / re-cache state and result of one item.
// ----------------------------------------------------------------------------
module pbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  pbc_pkg::cfg_t       cfg_i,
  input  logic                fire_i,
  input  pbc_pkg::in_item_t   item_i,
  output pbc_pkg::out_item_t  res_o
);
  import pbc_pkg::*;

  mode_t              mode_r,          mode_nxt;
  logic               clk_started_r,   clk_started_nxt;
  logic [TS_W-1:0]    start_sys_r,     start_sys_nxt;
  logic [TS_W-1:0]    start_stream_r,  start_stream_nxt;
  logic [TS_W-1:0]    deadline_r,      deadline_nxt;
  logic [RMS_W-1:0]   recache_ms_r,    recache_ms_nxt;
  logic [STEPS_W-1:0] steps_r,         steps_nxt;
  logic               audio_seen_r,    audio_seen_nxt;
  logic               fast_on_r,       fast_on_nxt;
  logic               fast_armed_r,    fast_armed_nxt;
  logic [TS_W-1:0]    position_r,      position_nxt;
  logic [TS_W-1:0]    last_span_r,     last_span_nxt;

  logic [TS_W-1:0]    audio_span;
  logic [TS_W-1:0]    video_span;
  logic [TS_W-1:0]    elapsed;
  logic               use_video;
  logic [TS_W-1:0]    span;
  logic [TS_W-1:0]    due;
  logic [TS_W-1:0]    red_x1;
  logic [TS_W-1:0]    red_x2;
  logic [TS_W-1:0]    red_x4;
  logic [12:0]        step_prod;
  logic [6:0]         steps_dbl;
  logic [STEPS_W-1:0] steps_grow;
  logic [RMS_W-1:0]   thr;
  logic               start_p, pause_p, rel_p;

  assign audio_span = item_i.audio_back_ts - item_i.audio_front_ts;
  assign video_span = item_i.video_back_ts - item_i.video_front_ts;
  assign elapsed    = item_i.now_ms - start_sys_r;
  assign red_x1     = TS_W'(cfg_i.redundancy_ms);
  assign red_x2     = TS_W'({cfg_i.redundancy_ms, 1'b0});
  assign red_x4     = TS_W'({cfg_i.redundancy_ms, 2'b00});

  // Video span stands in for the buffer level until the first audio item arrives.
  assign use_video  = !(item_i.audio_present && (audio_span != '0)) && !audio_seen_r &&
                      item_i.video_present;
  assign span       = use_video ? video_span : (item_i.audio_present ? audio_span : '0);
  assign due        = use_video ? (start_stream_r + elapsed) : position_r;

  assign step_prod  = 13'(steps_r) * 13'(STEP_MS);
  assign steps_dbl  = (steps_r < cfg_i.max_cache_steps) ? {steps_r, 1'b0} : {1'b0, steps_r};
  assign steps_grow = (steps_dbl >= {1'b0, cfg_i.max_cache_steps}) ?
                      cfg_i.max_cache_steps : steps_dbl[STEPS_W-1:0];
  assign thr        = (recache_ms_r > cfg_i.redundancy_ms) ?
                      (recache_ms_r - cfg_i.redundancy_ms) : '0;

  always_comb begin
    mode_nxt         = mode_r;
    clk_started_nxt  = clk_started_r;
    start_sys_nxt    = start_sys_r;
    start_stream_nxt = start_stream_r;
    deadline_nxt     = deadline_r;
    recache_ms_nxt   = recache_ms_r;
    steps_nxt        = steps_r;
    audio_seen_nxt   = audio_seen_r;
    fast_on_nxt      = fast_on_r;
    fast_armed_nxt   = fast_armed_r;
    position_nxt     = position_r;
    last_span_nxt    = last_span_r;
    start_p          = 1'b0;
    pause_p          = 1'b0;
    rel_p            = 1'b0;

    unique case (kind_t'(item_i.kind))
      KIND_TICK: begin
        if (clk_started_r) begin
          unique case (mode_r)
            MODE_FAST: begin
              if (elapsed >= red_x1) begin
                if (item_i.audio_present) begin
                  if (audio_span > red_x1) begin
                    mode_nxt     = MODE_NORMAL;
                    position_nxt = item_i.audio_front_ts;
                    start_p      = 1'b1;
                  end
                end else if (elapsed >= red_x4 && item_i.video_present) begin
                  mode_nxt     = MODE_NORMAL;
                  position_nxt = item_i.video_front_ts;
                  start_p      = 1'b1;
                end
              end
            end
            MODE_NORMAL: begin
              rel_p = item_i.video_present && (item_i.video_front_ts <= due);
              if (span <= red_x1) begin
                pause_p        = 1'b1;
                mode_nxt       = MODE_RECACHE;
                recache_ms_nxt = RMS_W'(step_prod);
                steps_nxt      = steps_grow;
                deadline_nxt   = item_i.now_ms + TS_W'(RMS_W'(step_prod));
              end else if (span >= TS_W'(cfg_i.fast_play_ms)) begin
                if (fast_armed_r) begin
                  fast_on_nxt    = 1'b1;
                  fast_armed_nxt = 1'b0;
                end
              end else if (span <= red_x2) begin
                fast_armed_nxt = 1'b1;
                fast_on_nxt    = 1'b0;
              end
              last_span_nxt = span;
            end
            default: begin
              if (deadline_r <= item_i.now_ms) begin
                if (span >= TS_W'(thr)) begin
                  mode_nxt = MODE_NORMAL;
                  if (steps_r >= cfg_i.max_cache_steps) begin
                    steps_nxt = steps_r >> 1;
                  end
                  start_p = 1'b1;
                end else begin
                  deadline_nxt = item_i.now_ms + TS_W'(recache_ms_r);
                end
                // Without audio the clock origin slides by the time spent re-caching.
                if (!audio_seen_r) begin
                  start_sys_nxt = start_sys_r + TS_W'(recache_ms_r);
                end
                last_span_nxt = span;
              end
            end
          endcase
        end
      end
      KIND_VIDEO: begin
        if (!clk_started_r) begin
          clk_started_nxt  = 1'b1;
          start_sys_nxt    = item_i.now_ms;
          start_stream_nxt = item_i.packet_ts;
        end
      end
      KIND_AUDIO: begin
        audio_seen_nxt = 1'b1;
        if (!clk_started_r && (audio_span >= TS_W'(cfg_i.start_span_ms))) begin
          clk_started_nxt  = 1'b1;
          start_sys_nxt    = item_i.now_ms;
          start_stream_nxt = item_i.packet_ts;
        end
      end
      default: begin
        position_nxt = item_i.packet_ts;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_FAST;
      clk_started_r  <= 1'b0;
      start_sys_r    <= '0;
      start_stream_r <= '0;
      deadline_r     <= '0;
      recache_ms_r   <= RECACHE_MS_RST;
      steps_r        <= STEPS_RST;
      audio_seen_r   <= 1'b0;
      fast_on_r      <= 1'b0;
      fast_armed_r   <= 1'b1;
      position_r     <= '0;
      last_span_r    <= LAST_SPAN_RST;
    end else if (fire_i) begin
      mode_r         <= mode_nxt;
      clk_started_r  <= clk_started_nxt;
      start_sys_r    <= start_sys_nxt;
      start_stream_r <= start_stream_nxt;
      deadline_r     <= deadline_nxt;
      recache_ms_r   <= recache_ms_nxt;
      steps_r        <= steps_nxt;
      audio_seen_r   <= audio_seen_nxt;
      fast_on_r      <= fast_on_nxt;
      fast_armed_r   <= fast_armed_nxt;
      position_r     <= position_nxt;
      last_span_r    <= last_span_nxt;
    end
  end

  always_comb begin
    res_o.start_play    = start_p;
    res_o.pause_play    = pause_p;
    res_o.release_video = rel_p;
    res_o.play_state    = mode_code(mode_nxt);
    res_o.fast_audio    = fast_on_nxt;
    res_o.buffered_ms   = last_span_nxt;
    res_o.play_position = position_nxt;
  end

  a_pause_enters_recache: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && pause_p |=> mode_r == MODE_RECACHE)
    else $error("pause did not enter re-cache");

  a_start_enters_normal: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && start_p |=> mode_r == MODE_NORMAL)
    else $error("start did not enter normal state");

  a_clock_stays_started: assert property (@(posedge clk) disable iff (!rst_n)
    clk_started_r |=> clk_started_r)
    else $error("playout clock stopped");

  a_playing_needs_clock: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_FAST |-> clk_started_r)
    else $error("left fast start without a running clock");

endmodule

/* hw/rtl/playout_buffer_controller_core.sv */
// ----------------------------------------------------------------------------
// Playout buffer controller
// Jitter buffer playout control: clock start, pause/resume and fast audio.
// ----------------------------------------------------------------------------
// Path: an item waits in the input register and its result in the output register.
// Throughput: one item per cycle while out.ready holds; one pass of update logic.
// Back pressure: the input register drains into the output register whenever that
// register is empty or being read, so in.ready stays high under a steady stream.
// Reset (synchronous, rst_n low): fast start state, clock stopped, registers at
// their defaults; no clearing pass is needed.
module playout_buffer_controller_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [pbc_pkg::CFG_W-1:0] cfg_wdata,
  pbc_in_if.sink                    in_item,
  pbc_out_if.source                 out_item
);
  import pbc_pkg::*;

  cfg_t      cfg;
  logic      in_vld_r;
  in_item_t  in_data_r;
  logic      out_vld_r;
  out_item_t out_data_r;
  logic      fire;
  out_item_t res;

  pbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  assign fire          = in_vld_r && (!out_vld_r || out_item.ready);
  assign in_item.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_item.ready) begin
      in_vld_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      in_data_r.kind           <= in_item.kind;
      in_data_r.now_ms         <= in_item.now_ms;
      in_data_r.packet_ts      <= in_item.packet_ts;
      in_data_r.audio_present  <= in_item.audio_present;
      in_data_r.audio_front_ts <= in_item.audio_front_ts;
      in_data_r.audio_back_ts  <= in_item.audio_back_ts;
      in_data_r.video_present  <= in_item.video_present;
      in_data_r.video_front_ts <= in_item.video_front_ts;
      in_data_r.video_back_ts  <= in_item.video_back_ts;
    end
  end

  pbc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (in_data_r),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_item.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_item.valid         = out_vld_r;
  assign out_item.start_play    = out_data_r.start_play;
  assign out_item.pause_play    = out_data_r.pause_play;
  assign out_item.release_video = out_data_r.release_video;
  assign out_item.play_state    = out_data_r.play_state;
  assign out_item.fast_audio    = out_data_r.fast_audio;
  assign out_item.buffered_ms   = out_data_r.buffered_ms;
  assign out_item.play_position = out_data_r.play_position;

endmodule

/* bench/playout_buffer_controller_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Playout buffer controller regression
// Drives timer, video, audio and played events into the playout controller,
// predicts every result with an independent model of the playout state and
// checks each result field by field under several register settings.
// ----------------------------------------------------------------------------
module playout_buffer_controller_core_tb;
  import pbc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 85;

  // Tracks the playout state of the controller and the results it owes.
  class playout_tracker;
    logic [CFG_W-1:0]   redundancy, fast_play, start_span;
    logic [STEPS_W-1:0] max_steps;
    logic [1:0]         mode;
    bit                 clock_started, audio_seen, fast_on, fast_armed;
    logic [TS_W-1:0]    start_sys, start_stream, deadline, position, last_span;
    logic [RMS_W-1:0]   recache_ms;
    int unsigned        steps;
    out_item_t          expected_outcomes[$];
    int unsigned        mismatches, results_checked;
    int unsigned        kind_count[4];
    int unsigned        resumes, pauses, releases, fast_switches;

    function new();
      redundancy    = REDUNDANCY_RST;
      fast_play     = FAST_PLAY_RST;
      start_span    = START_SPAN_RST;
      max_steps     = MAX_STEPS_RST;
      mode          = PLAY_ST_FAST;
      clock_started = 0;
      audio_seen    = 0;
      fast_on       = 0;
      fast_armed    = 1;
      start_sys     = '0;
      start_stream  = '0;
      deadline      = '0;
      position      = '0;
      last_span     = LAST_SPAN_RST;
      recache_ms    = RECACHE_MS_RST;
      steps         = 32'(STEPS_RST);
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_REDUNDANCY: redundancy = value;
        CFG_FAST_PLAY:  fast_play  = value;
        CFG_START_SPAN: start_span = value;
        CFG_MAX_STEPS:  max_steps  = value[STEPS_W-1:0];
      endcase
    endfunction

    function logic [TS_W-1:0] span_of(logic [TS_W-1:0] back, logic [TS_W-1:0] front);
      return back - front;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t       want;
      logic [TS_W-1:0] gap, span, due;
      logic [RMS_W-1:0] thr;
      want = '0;
      kind_count[ev.kind]++;
      case (kind_t'(ev.kind))
        KIND_TICK: begin
          if (clock_started && mode == PLAY_ST_FAST) begin
            gap = ev.now_ms - start_sys;
            if (gap >= redundancy) begin
              if (ev.audio_present) begin
                if (span_of(ev.audio_back_ts, ev.audio_front_ts) > redundancy) begin
                  mode = PLAY_ST_NORMAL;
                  position = ev.audio_front_ts;
                  want.start_play = 1;
                end
              end else if (gap >= {redundancy, 2'b00} && ev.video_present) begin
                mode = PLAY_ST_NORMAL;
                position = ev.video_front_ts;
                want.start_play = 1;
              end
            end
          end else if (clock_started && mode == PLAY_ST_NORMAL) begin
            span = ev.audio_present ? span_of(ev.audio_back_ts, ev.audio_front_ts) : '0;
            due = position;
            // Before any audio, video alone paces the clock from the start time.
            if (span == 0 && !audio_seen && ev.video_present) begin
              span = span_of(ev.video_back_ts, ev.video_front_ts);
              due = start_stream + (ev.now_ms - start_sys);
            end
            if (ev.video_present && ev.video_front_ts <= due) want.release_video = 1;
            if (span <= redundancy) begin
              want.pause_play = 1;
              mode = PLAY_ST_RECACHE;
              recache_ms = RMS_W'(steps * STEP_MS);
              if (steps < max_steps) steps = steps * 2;
              if (steps >= max_steps) steps = 32'(max_steps);
              deadline = ev.now_ms + recache_ms;
            end else if (span >= fast_play) begin
              if (fast_armed) begin
                fast_on = 1;
                fast_armed = 0;
                fast_switches++;
              end
            end else if (span <= {redundancy, 1'b0}) begin
              fast_armed = 1;
              fast_on = 0;
            end
            last_span = span;
          end else if (clock_started && deadline <= ev.now_ms) begin
            span = ev.audio_present ? span_of(ev.audio_back_ts, ev.audio_front_ts) : '0;
            if (span == 0 && !audio_seen && ev.video_present)
              span = span_of(ev.video_back_ts, ev.video_front_ts);
            thr = (recache_ms > redundancy) ? recache_ms - redundancy : '0;
            if (span >= thr) begin
              mode = PLAY_ST_NORMAL;
              if (steps >= max_steps) steps = steps / 2;
              want.start_play = 1;
            end else begin
              deadline = ev.now_ms + recache_ms;
            end
            if (!audio_seen) start_sys = start_sys + recache_ms;
            last_span = span;
          end
        end
        KIND_VIDEO: begin
          if (!clock_started) begin
            clock_started = 1;
            start_sys = ev.now_ms;
            start_stream = ev.packet_ts;
          end
        end
        KIND_AUDIO: begin
          audio_seen = 1;
          if (!clock_started &&
              span_of(ev.audio_back_ts, ev.audio_front_ts) >= start_span) begin
            clock_started = 1;
            start_sys = ev.now_ms;
            start_stream = ev.packet_ts;
          end
        end
        KIND_PLAYED: position = ev.packet_ts;
      endcase
      if (want.start_play) resumes++;
      if (want.pause_play) pauses++;
      if (want.release_video) releases++;
      want.play_state    = mode;
      want.fast_audio    = fast_on;
      want.buffered_ms   = last_span;
      want.play_position = position;
      expected_outcomes.insert(expected_outcomes.size(), want);
    endfunction

    task note_mismatch(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [TS_W-1:0] got, logic [TS_W-1:0] want);
      if (got !== want)
        note_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_checked, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_outcomes.size() == 0) begin
        note_mismatch($sformatf("result with no event waiting: state %0d position %0h",
                                got.play_state, got.play_position));
        return;
      end
      want = expected_outcomes[0];
      expected_outcomes.delete(0);
      results_checked++;
      check_field("start_play",    got.start_play,    want.start_play);
      check_field("pause_play",    got.pause_play,    want.pause_play);
      check_field("release_video", got.release_video, want.release_video);
      check_field("play_state",    got.play_state,    want.play_state);
      check_field("fast_audio",    got.fast_audio,    want.fast_audio);
      check_field("buffered_ms",   got.buffered_ms,   want.buffered_ms);
      check_field("play_position", got.play_position, want.play_position);
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  bit                idle_on;
  logic [TS_W-1:0]   sim_now;
  int unsigned       quiet_cycles;
  playout_tracker    tracker = new();

  pbc_in_if  ev_ch ();
  pbc_out_if res_ch ();

  playout_buffer_controller_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item  (ev_ch),
    .out_item (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : watch_handshakes
    in_item_t  ev_seen;
    out_item_t res_seen;
    if (rst_n) begin
      if (ev_ch.valid && ev_ch.ready) begin
        ev_seen = '{ev_ch.kind, ev_ch.now_ms, ev_ch.packet_ts, ev_ch.audio_present,
                    ev_ch.audio_front_ts, ev_ch.audio_back_ts, ev_ch.video_present,
                    ev_ch.video_front_ts, ev_ch.video_back_ts};
        tracker.note_event(ev_seen);
      end
      if (res_ch.valid && res_ch.ready) begin
        res_seen = '{res_ch.start_play, res_ch.pause_play, res_ch.release_video,
                     res_ch.play_state, res_ch.fast_audio, res_ch.buffered_ms,
                     res_ch.play_position};
        tracker.check_result(res_seen);
      end
      if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("playout_buffer_controller_core regression: fail");
    $finish;
  end

  // Result side: random stalls while idle_on is set, plus two long hold-offs that fill the block.
  initial begin : result_sink
    int unsigned stall, taken;
    taken = 0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 11) : 0;
      if (taken == 150 || taken == 420) stall = 80;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      taken++;
    end
  end

  function automatic in_item_t build(kind_t k, logic [TS_W-1:0] now, logic [TS_W-1:0] pts,
                                     logic ap, logic [TS_W-1:0] af, logic [TS_W-1:0] ab,
                                     logic vp, logic [TS_W-1:0] vf, logic [TS_W-1:0] vb);
    return '{k, now, pts, ap, af, ab, vp, vf, vb};
  endfunction

  // Spans near the thresholds that the current registers define.
  function automatic logic [TS_W-1:0] pick_span();
    logic [TS_W-1:0] red, fst;
    red = TS_W'(tracker.redundancy);
    fst = TS_W'(tracker.fast_play);
    case ($urandom_range(0, 10))
      0:       return '0;
      1:       return $urandom_range(0, red);
      2:       return red;
      3:       return red + 1;
      4:       return red * 2;
      5:       return red * 2 + 1;
      6:       return fst - TS_W'($urandom_range(0, 1));
      7:       return $urandom_range(red + 1, fst + 1);
      8:       return fst + TS_W'($urandom_range(0, 3000));
      9:       return TS_W'(tracker.recache_ms) - red + TS_W'($urandom_range(0, 2)) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t next_event();
    in_item_t    ev;
    int unsigned pick;
    if ($urandom_range(0, 99) < 15) begin
      ev = '{2'($urandom), $urandom, $urandom, 1'($urandom), $urandom, $urandom,
             1'($urandom), $urandom, $urandom};
      return ev;
    end
    sim_now = sim_now + TS_W'($urandom_range(0, 250));
    if ($urandom_range(0, 199) == 0) sim_now = 32'hFFFF_FF00;
    // Aim some event times right at the re-cache deadline.
    if (tracker.mode == PLAY_ST_RECACHE && $urandom_range(0, 3) == 0)
      sim_now = tracker.deadline + TS_W'($urandom_range(0, 4)) - 1;
    ev.now_ms         = sim_now;
    ev.packet_ts      = tracker.position + TS_W'($urandom_range(0, 300));
    ev.audio_present  = ($urandom_range(0, 9) != 0);
    ev.audio_front_ts = tracker.position + TS_W'($urandom_range(0, 400)) - 200;
    ev.audio_back_ts  = ev.audio_front_ts + pick_span();
    ev.video_present  = ($urandom_range(0, 4) != 0);
    ev.video_front_ts = tracker.position + TS_W'($urandom_range(0, 400)) - 200;
    ev.video_back_ts  = ev.video_front_ts + pick_span();
    pick = $urandom_range(0, 99);
    if (pick < 60)      ev.kind = KIND_TICK;
    else if (pick < 80) ev.kind = KIND_PLAYED;
    else if (pick < 90) ev.kind = KIND_AUDIO;
    else                ev.kind = KIND_VIDEO;
    return ev;
  endfunction

  task automatic send_event(in_item_t ev);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_ch.valid          <= 1'b1;
    ev_ch.kind           <= ev.kind;
    ev_ch.now_ms         <= ev.now_ms;
    ev_ch.packet_ts      <= ev.packet_ts;
    ev_ch.audio_present  <= ev.audio_present;
    ev_ch.audio_front_ts <= ev.audio_front_ts;
    ev_ch.audio_back_ts  <= ev.audio_back_ts;
    ev_ch.video_present  <= ev.video_present;
    ev_ch.video_front_ts <= ev.video_front_ts;
    ev_ch.video_back_ts  <= ev.video_back_ts;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.set_register(idx, value);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] red_set[PHASES]   = '{200, 0, 16'hFFFF, 50, 20, 100, 200};
    logic [CFG_W-1:0] fast_set[PHASES]  = '{1500, 0, 16'hFFFF, 400, 300, 1000, 1500};
    logic [CFG_W-1:0] start_set[PHASES] = '{1000, 0, 16'hFFFF, 100, 500, 1000, 1000};
    // Upper bits beyond the 6-bit limit register are written too.
    logic [CFG_W-1:0] max_set[PHASES]   = '{30, 1, 16'hFFFF, 16'h0FC0, 5, 63, 30};
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_REDUNDANCY;
    cfg_wdata            <= '0;
    ev_ch.valid          <= 1'b0;
    ev_ch.kind           <= KIND_TICK;
    ev_ch.now_ms         <= '0;
    ev_ch.packet_ts      <= '0;
    ev_ch.audio_present  <= 1'b0;
    ev_ch.audio_front_ts <= '0;
    ev_ch.audio_back_ts  <= '0;
    ev_ch.video_present  <= 1'b0;
    ev_ch.video_front_ts <= '0;
    ev_ch.video_back_ts  <= '0;
    idle_on = 1;
    sim_now = 32'h0000_1000;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fast start: ticks do nothing until a video item starts the clock.
    send_event(build(KIND_TICK, '1, '1, 1, '1, '0, 1, '1, '0));
    send_event(build(KIND_PLAYED, '0, '1, 0, '0, '0, 0, '0, '0));
    send_event(build(KIND_VIDEO, 1000, 5000, 0, 0, 0, 1, 5000, 5040));
    send_event(build(KIND_TICK, 1100, 0, 0, 0, 0, 1, 5000, 5400));
    send_event(build(KIND_TICK, 1300, 0, 1, 5000, 5100, 1, 5000, 5400));
    send_event(build(KIND_TICK, 1900, 0, 1, 5000, 5100, 1, 5000, 5400));
    send_event(build(KIND_TICK, 1900, 0, 0, 0, 0, 1, 5000, 5400));
    // Normal play paced by video alone, fast audio on and off, then underrun.
    send_event(build(KIND_TICK, 2000, 0, 0, 0, 0, 1, 5050, 5600));
    send_event(build(KIND_TICK, 2050, 0, 0, 0, 0, 1, 9000, 11000));
    send_event(build(KIND_TICK, 2060, 0, 0, 0, 0, 1, 9000, 10600));
    send_event(build(KIND_TICK, 2070, 0, 0, 0, 0, 1, 9000, 9300));
    send_event(build(KIND_TICK, 2080, 0, 0, 0, 0, 1, 9000, 9150));
    send_event(build(KIND_TICK, 2179, 0, 0, 0, 0, 1, 6000, 6050));
    send_event(build(KIND_TICK, 2180, 0, 0, 0, 0, 1, 6000, 6050));
    // Audio arrival ignores the present flag and takes a wrapped span as given.
    send_event(build(KIND_AUDIO, 2200, 7000, 0, 1, 0, 0, 0, 0));
    send_event(build(KIND_VIDEO, 2210, 123, 1, 0, 0, 1, 0, 0));
    send_event(build(KIND_PLAYED, 2220, 6000, 0, 0, 0, 0, 0, 0));
    send_event(build(KIND_TICK, 2300, 0, 1, 6000, 9000, 1, 5990, 6100));
    send_event(build(KIND_TICK, 2310, 0, 1, 32'hFFFF_FF00, 32'h100, 1, 6000, 6100));
    send_event(build(KIND_TICK, 2320, 0, 1, 7000, 7200, 1, 0, 10));
    send_event(build(KIND_TICK, 2519, 0, 1, 7000, 7000, 1, 1, 1000));
    send_event(build(KIND_TICK, 2520, 0, 1, 7000, 7000, 1, 1, 1000));
    // The deadline wraps past zero but is compared without wrap.
    send_event(build(KIND_TICK, 32'hFFFF_FFF0, 0, 0, 0, 0, 1, 1, 1000));
    send_event(build(KIND_TICK, 32'h10, 0, 1, 0, 1000, 0, 0, 0));
    send_event(build(KIND_TICK, 32'h200, 0, 1, 0, 1000, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        put_register(CFG_REDUNDANCY, red_set[p]);
        put_register(CFG_FAST_PLAY, fast_set[p]);
        put_register(CFG_START_SPAN, start_set[p]);
        put_register(CFG_MAX_STEPS, max_set[p]);
        cfg_we <= 1'b0;
      end
      idle_on = !(p == 1 || p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_event(next_event());
      end
    end

    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.expected_outcomes.size() != 0)
      tracker.note_mismatch($sformatf("%0d results never arrived",
                                      tracker.expected_outcomes.size()));
    $display("Covered %0d ticks, %0d video, %0d audio and %0d played events over %0d settings.",
             tracker.kind_count[KIND_TICK], tracker.kind_count[KIND_VIDEO],
             tracker.kind_count[KIND_AUDIO], tracker.kind_count[KIND_PLAYED], PHASES);
    $display("Checked %0d results: %0d resumes, %0d pauses, %0d releases, %0d fast switches.",
             tracker.results_checked, tracker.resumes, tracker.pauses,
             tracker.releases, tracker.fast_switches);
    if (tracker.mismatches == 0) begin
      $display("playout_buffer_controller_core regression: pass");
    end else begin
      $display("playout_buffer_controller_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pbc_pkg.sv
hw/rtl/pbc_if.sv
hw/rtl/pbc_cfg_regs.sv
hw/rtl/pbc_ctrl.sv
hw/rtl/playout_buffer_controller_core.sv
bench/playout_buffer_controller_core_tb.sv
